// ===== design/rtpc_pkg.sv =====
// ----------------------------------------------------------------------------
// rtpc_pkg: shared types and constants for the region table point classifier
// Table depth, coordinate width, operation and status codes, entry record.
// ----------------------------------------------------------------------------
package rtpc_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int COORD_BITS  = 32;
    localparam int SLOT_BITS   = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;
    localparam logic [1:0] FUNC_FIND   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;

    localparam logic KIND_SPHERE = 1'b0;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [23:0] id;
        logic        kind;
        logic [15:0] universe;
        coord_t      ax;
        coord_t      ay;
        coord_t      az;
        coord_t      bx;
        coord_t      by;
        coord_t      bz;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

endpackage

// ===== design/rtpc_ram.sv =====
// ----------------------------------------------------------------------------
// rtpc_ram: region table storage
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module rtpc_ram
    import rtpc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [SLOT_BITS-1:0] wr_addr,
    input  entry_t               wr_data,
    input  logic [SLOT_BITS-1:0] rd_addr,
    output entry_t               rd_data
);

    entry_t mem [TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/region_table_point_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// region_table_point_classifier_unit: ordered region table with point lookup
// Add, remove (with compaction), find by id, and first-containing-region query.
// ----------------------------------------------------------------------------
//  channel | dir | ports
//  s_      | in  | s_valid/s_ready, func, region_id, kind, universe, a*, b*
//  m_      | out | m_valid/m_ready, status, hit_id, hit_slot, entry_count
//
// One word at a time. Add writes on accept; result follows via S_DONE. Find,
// remove and query scan in table order, each entry read, then checked; a sphere
// of the queried universe adds squaring steps (one shared 33x33 multiplier squares
// dx, dy, dz, r in turn). Remove then moves each later entry down (1 port).
// Result sits in an output register; s_ready is low until it is taken.
// Synchronous active-low reset clears the count and control; table is not cleared.
module region_table_point_classifier_unit
    import rtpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [23:0] s_region_id,
    input  logic        s_kind,
    input  logic [15:0] s_universe,
    input  logic signed [31:0] s_ax,
    input  logic signed [31:0] s_ay,
    input  logic signed [31:0] s_az,
    input  logic signed [31:0] s_bx,
    input  logic signed [31:0] s_by,
    input  logic signed [31:0] s_bz,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [23:0] m_hit_id,
    output logic [5:0]  m_hit_slot,
    output logic [6:0]  m_entry_count
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;  // address issued, wait data
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;  // sphere squaring steps
    localparam logic [2:0] S_MOVE  = 3'd4;  // compaction
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam int DW = COORD_BITS + 1;      // abs difference width
    localparam int PW = 2 * DW + 2;          // sum of three squares

    logic [2:0]           state_reg, state_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [CNT_BITS-1:0]  idx_reg, idx_next;
    logic [1:0]           step_reg, step_next;
    logic [1:0]           func_reg;
    logic [23:0]          id_reg;
    logic [15:0]          uni_reg;
    coord_t               px_reg, py_reg, pz_reg;
    logic [PW-1:0]        acc_reg, acc_next;
    logic [2*DW-1:0]      prod_reg;
    logic                 prod_vld_next;
    logic [DW-1:0]        mop_reg, mop_next;
    logic                 ovalid_reg;
    logic [1:0]           ostatus_reg;
    logic [23:0]          oid_reg;
    logic [5:0]           oslot_reg;
    logic                 ovalid_next;
    logic [1:0]           ostatus_next;
    logic [23:0]          oid_next;
    logic [5:0]           oslot_next;

    logic                 wr_en;
    logic [SLOT_BITS-1:0] wr_addr, rd_addr;
    entry_t               wr_data, rd_data;

    rtpc_ram u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    function automatic logic [DW-1:0] absdiff(coord_t a, coord_t b);
        logic signed [DW-1:0] d;
        begin
            d = DW'(a) - DW'(b);
            absdiff = d[DW-1] ? DW'(-d) : DW'(d);
        end
    endfunction

    logic s_fire;
    assign s_fire  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE) && !ovalid_reg;

    logic box_in;
    assign box_in = px_reg >= rd_data.ax && px_reg <= rd_data.bx &&
                    py_reg >= rd_data.ay && py_reg <= rd_data.by &&
                    pz_reg >= rd_data.az && pz_reg <= rd_data.bz;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        step_next     = step_reg;
        acc_next      = acc_reg;
        prod_vld_next = 1'b0;
        mop_next      = mop_reg;
        ovalid_next   = ovalid_reg;
        ostatus_next  = ostatus_reg;
        oid_next      = oid_reg;
        oslot_next    = oslot_reg;
        wr_en         = 1'b0;
        wr_addr       = idx_reg[SLOT_BITS-1:0];
        wr_data       = rd_data;
        rd_addr       = idx_reg[SLOT_BITS-1:0];

        if (ovalid_reg && m_ready) begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                idx_next = '0;
                rd_addr  = '0;
                if (s_fire) begin
                    ostatus_next = ST_NOMATCH;
                    oid_next     = '0;
                    oslot_next   = '0;
                    if (s_func == FUNC_ADD) begin
                        if (count_reg == CNT_BITS'(TABLE_DEPTH)) begin
                            ostatus_next = ST_FULL;
                        end else begin
                            wr_en        = 1'b1;
                            wr_addr      = count_reg[SLOT_BITS-1:0];
                            wr_data      = '{s_region_id, s_kind, s_universe,
                                             s_ax, s_ay, s_az, s_bx, s_by, s_bz};
                            ostatus_next = ST_OK;
                            oid_next     = s_region_id;
                            oslot_next   = 6'(count_reg);
                            count_next   = count_reg + 1'b1;
                        end
                        state_next = S_DONE;
                    end else if (count_reg == '0) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                step_next = '0;
                if (func_reg == FUNC_QUERY) begin
                    if (rd_data.universe != uni_reg) begin
                        idx_next = idx_reg + 1'b1;
                    end else if (rd_data.kind != KIND_SPHERE) begin
                        if (box_in) begin
                            ostatus_next = ST_OK;
                            oid_next     = rd_data.id;
                            oslot_next   = 6'(idx_reg);
                            state_next   = S_DONE;
                        end else begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end else begin
                        acc_next      = '0;
                        mop_next      = absdiff(rd_data.ax, px_reg);
                        prod_vld_next = 1'b1;
                        state_next    = S_MUL;
                    end
                end else if (rd_data.id == id_reg) begin
                    ostatus_next = ST_OK;
                    oid_next     = id_reg;
                    oslot_next   = 6'(idx_reg);
                    if (func_reg == FUNC_REMOVE) begin
                        state_next = S_MOVE;
                        idx_next   = idx_reg + 1'b1;
                    end else begin
                        state_next = S_DONE;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
                if (state_next == S_CHECK) begin
                    if (idx_next == count_reg) begin
                        state_next = S_DONE;
                    end else begin
                        rd_addr    = idx_next[SLOT_BITS-1:0];
                        state_next = S_READ;
                    end
                end
            end
            S_MUL: begin
                // step 0..2 accumulate dx^2, dy^2, dz^2; step 3 has r^2
                step_next     = step_reg + 1'b1;
                prod_vld_next = step_reg != 2'd3;
                unique case (step_reg)
                    2'd0: mop_next = absdiff(rd_data.ay, py_reg);
                    2'd1: mop_next = absdiff(rd_data.az, pz_reg);
                    2'd2: mop_next = absdiff(rd_data.bx, '0);
                    default: mop_next = mop_reg;
                endcase
                if (step_reg != 2'd3) begin
                    acc_next = acc_reg + PW'(prod_reg);
                end else begin
                    if (acc_reg <= PW'(prod_reg)) begin
                        ostatus_next = ST_OK;
                        oid_next     = rd_data.id;
                        oslot_next   = 6'(idx_reg);
                        state_next   = S_DONE;
                    end else if (idx_reg + 1'b1 == count_reg) begin
                        state_next = S_DONE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        rd_addr    = SLOT_BITS'(idx_reg + 1'b1);
                        state_next = S_READ;
                    end
                end
            end
            S_MOVE: begin
                // read entry idx, then write it at idx-1
                if (idx_reg == count_reg) begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end else begin
                    rd_addr    = idx_reg[SLOT_BITS-1:0];
                    step_next  = 2'd1;
                    state_next = S_READ;
                end
            end
            S_DONE: begin
                ovalid_next = 1'b1;
                state_next  = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase

        // compaction reuses S_READ: after data arrives, write it one slot down
        if (state_reg == S_READ && func_reg == FUNC_REMOVE && ostatus_reg == ST_OK
            && step_reg == 2'd1) begin
            state_next = S_MOVE;
        end
        if (state_reg == S_MOVE && step_reg == 2'd1) begin
            wr_en     = 1'b1;
            wr_addr   = SLOT_BITS'(idx_reg - 1'b1);
            wr_data   = rd_data;
            step_next = '0;
            idx_next  = idx_reg + 1'b1;
            state_next = S_MOVE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            ovalid_reg   <= 1'b0;
            step_reg     <= '0;
            ostatus_reg  <= ST_NOMATCH;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovalid_reg   <= ovalid_next;
            step_reg     <= step_next;
            ostatus_reg  <= ostatus_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        acc_reg   <= acc_next;
        mop_reg   <= mop_next;
        oid_reg   <= oid_next;
        oslot_reg <= oslot_next;
        if (prod_vld_next) begin
            prod_reg <= (2*DW)'(mop_next) * (2*DW)'(mop_next);
        end
        if (s_fire) begin
            func_reg <= s_func;
            id_reg   <= s_region_id;
            uni_reg  <= s_universe;
            px_reg   <= s_ax;
            py_reg   <= s_ay;
            pz_reg   <= s_az;
        end
    end

    assign m_valid       = ovalid_reg;
    assign m_status      = ostatus_reg;
    assign m_hit_id      = oid_reg;
    assign m_hit_slot    = oslot_reg;
    assign m_entry_count = 7'(count_reg);

endmodule
